/* sv/stl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

	typedef enum logic [3:0] {
		KIND_IDENT  = 4'd0,
		KIND_PROC   = 4'd1,
		KIND_VAR    = 4'd2,
		KIND_NUMBER = 4'd3,
		KIND_LPAREN = 4'd4,
		KIND_RPAREN = 4'd5,
		KIND_COMMA  = 4'd6,
		KIND_LBRACE = 4'd7,
		KIND_RBRACE = 4'd8,
		KIND_SEMI   = 4'd9,
		KIND_STAR   = 4'd10,
		KIND_EQUAL  = 4'd11,
		KIND_EOF    = 4'd12,
		KIND_ERROR  = 4'd13
	} kind_t;

	localparam int TOK_POS_W = 16;

	// output queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_EQUAL  = 8'h3d;

	typedef struct packed {
		kind_t                  kind;
		logic [TOK_POS_W-1:0]   start;
		logic [TOK_POS_W-1:0]   stop;
		logic                   last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} scan_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || (c == 8'h5f);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

`default_nettype wire

/* sv/stl_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module stl_scan #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        text_byte,
	output stl_pkg::scan_out_t     res
);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} mode_t;

	mode_t                    mode_q, mode_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n, begin_q, begin_n, pos_inc;
	logic [2:0]               ilen_q, ilen_n;
	logic                     proc_q, proc_n, var_q, var_n;

	logic                     has_a, has_b, cont;
	stl_pkg::token_t          tok_a, tok_b;
	logic                     punct_hit;
	stl_pkg::kind_t           punct_kind;

	function automatic logic [7:0] proc_char(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = 8'h70; // p
			2'd1:    r = 8'h72; // r
			2'd2:    r = 8'h6f; // o
			default: r = 8'h63; // c
		endcase
		return r;
	endfunction

	function automatic logic [7:0] var_char(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = 8'h76; // v
			2'd1:    r = 8'h61; // a
			default: r = 8'h72; // r
		endcase
		return r;
	endfunction

	assign pos_inc = (&pos_q) ? pos_q : pos_q + 1'b1;

	always_comb begin
		punct_hit  = 1'b1;
		punct_kind = stl_pkg::KIND_ERROR;
		unique case (text_byte)
			stl_pkg::CH_LPAREN: punct_kind = stl_pkg::KIND_LPAREN;
			stl_pkg::CH_RPAREN: punct_kind = stl_pkg::KIND_RPAREN;
			stl_pkg::CH_COMMA:  punct_kind = stl_pkg::KIND_COMMA;
			stl_pkg::CH_LBRACE: punct_kind = stl_pkg::KIND_LBRACE;
			stl_pkg::CH_RBRACE: punct_kind = stl_pkg::KIND_RBRACE;
			stl_pkg::CH_SEMI:   punct_kind = stl_pkg::KIND_SEMI;
			stl_pkg::CH_STAR:   punct_kind = stl_pkg::KIND_STAR;
			stl_pkg::CH_EQUAL:  punct_kind = stl_pkg::KIND_EQUAL;
			default:            punct_hit  = 1'b0;
		endcase
	end

	always_comb begin
		mode_n  = mode_q;
		pos_n   = pos_q;
		begin_n = begin_q;
		ilen_n  = ilen_q;
		proc_n  = proc_q;
		var_n   = var_q;
		has_a   = 1'b0;
		has_b   = 1'b0;
		cont    = 1'b0;
		tok_a   = '0;
		tok_b   = '0;

		// close a pending identifier or number
		tok_a.kind  = stl_pkg::KIND_IDENT;
		tok_a.start = stl_pkg::TOK_POS_W'(begin_q);
		tok_a.stop  = stl_pkg::TOK_POS_W'(pos_q);
		unique case (mode_q)
			MODE_IDENT: begin
				if (stl_pkg::is_letter(text_byte) || stl_pkg::is_digit(text_byte)) begin
					cont   = 1'b1;
					proc_n = proc_q && (ilen_q < 3'd4) && (text_byte == proc_char(ilen_q[1:0]));
					var_n  = var_q && (ilen_q < 3'd3) && (text_byte == var_char(ilen_q[1:0]));
					ilen_n = (ilen_q == 3'd7) ? ilen_q : ilen_q + 3'd1;
				end else begin
					has_a = 1'b1;
					if (proc_q && ilen_q == 3'd4)
						tok_a.kind = stl_pkg::KIND_PROC;
					else if (var_q && ilen_q == 3'd3)
						tok_a.kind = stl_pkg::KIND_VAR;
				end
			end
			MODE_NUMBER: begin
				if (stl_pkg::is_digit(text_byte)) begin
					cont = 1'b1;
				end else begin
					has_a      = 1'b1;
					tok_a.kind = stl_pkg::KIND_NUMBER;
				end
			end
			default: ;
		endcase

		tok_b.start = stl_pkg::TOK_POS_W'(pos_q);
		tok_b.stop  = stl_pkg::TOK_POS_W'(pos_q);
		tok_b.kind  = stl_pkg::KIND_ERROR;
		if (cont) begin
			pos_n = pos_inc;
		end else begin
			mode_n = MODE_IDLE;
			if (stl_pkg::is_space(text_byte)) begin
				pos_n = pos_inc;
			end else if (stl_pkg::is_letter(text_byte)) begin
				mode_n  = MODE_IDENT;
				begin_n = pos_q;
				ilen_n  = 3'd1;
				proc_n  = (text_byte == proc_char(2'd0));
				var_n   = (text_byte == var_char(2'd0));
				pos_n   = pos_inc;
			end else if (stl_pkg::is_digit(text_byte)) begin
				mode_n  = MODE_NUMBER;
				begin_n = pos_q;
				pos_n   = pos_inc;
			end else if (punct_hit) begin
				has_b      = 1'b1;
				tok_b.kind = punct_kind;
				tok_b.stop = stl_pkg::TOK_POS_W'(pos_inc);
				pos_n      = pos_inc;
			end else if (text_byte == stl_pkg::CH_NUL) begin
				has_b      = 1'b1;
				tok_b.kind = stl_pkg::KIND_EOF;
				pos_n      = '0;
				begin_n    = '0;
			end else begin
				has_b = 1'b1;
				pos_n = pos_inc;
			end
		end

		res = '0;
		if (has_a && has_b) begin
			res.count       = 2'd2;
			res.first       = tok_a;
			res.second      = tok_b;
			res.second.last = 1'b1;
		end else if (has_a) begin
			res.count      = 2'd1;
			res.first      = tok_a;
			res.first.last = 1'b1;
		end else if (has_b) begin
			res.count      = 2'd1;
			res.first      = tok_b;
			res.first.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			ilen_q  <= '0;
			proc_q  <= 1'b0;
			var_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			begin_q <= begin_n;
			ilen_q  <= ilen_n;
			proc_q  <= proc_n;
			var_q   <= var_n;
		end
	end

endmodule

`default_nettype wire

/* sv/source_token_lexer.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  beat
// s_*       in   one source byte (s_tdata[7:0] = text_byte)
// m_*       out  one token (kind, start, end); m_tlast = last token of its byte
//
// One byte is taken per cycle while s_tready is high. A byte goes into the
// input register, is scanned once the queue has room, and its tokens land
// in a 4-entry output queue for m_*. A byte that ends a word and is a token
// itself gives two beats, which drain one per cycle while m_tready is high;
// the queue's free space (two entries) decides when s_tready drops.
// arst_n clears the scanner state, position and queue.

module source_token_lexer #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] text_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // [3:0] token_kind, [19:4] token_start,
	                                   // [35:20] token_end, [39:36] zero
	output logic             m_tlast   // last_of_item
);

	logic [7:0]                   byte_s1;
	logic                         valid_s1;
	logic                         step;
	logic                         pop;
	stl_pkg::scan_out_t           res;
	logic [1:0]                   push_n;

	stl_pkg::token_t              ent_q [stl_pkg::QDEPTH];
	logic [stl_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [stl_pkg::QCNT_W-1:0]   cnt_q;
	stl_pkg::token_t              head;

	assign step     = valid_s1 && (cnt_q <= stl_pkg::QCNT_W'(stl_pkg::QDEPTH - 2));
	assign s_tready = !valid_s1 || step;
	assign push_n   = step ? res.count : 2'd0;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	stl_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			ent_q[wr_q] <= res.first;
		if (push_n == 2'd2)
			ent_q[wr_q + 1'b1] <= res.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + stl_pkg::QPTR_W'(push_n);
			rd_q  <= rd_q + stl_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + stl_pkg::QCNT_W'(push_n) - stl_pkg::QCNT_W'(pop);
		end
	end

	assign head     = ent_q[rd_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {4'b0000, head.stop, head.start, head.kind};
	assign m_tlast  = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= stl_pkg::QCNT_W'(stl_pkg::QDEPTH))
		else $error("output queue overflow");

	a_pair_closes_word: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.count == 2'd2 |->
			res.first.kind == stl_pkg::KIND_IDENT || res.first.kind == stl_pkg::KIND_PROC ||
			res.first.kind == stl_pkg::KIND_VAR || res.first.kind == stl_pkg::KIND_NUMBER)
		else $error("two tokens from one byte without a closed word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> res.count != 2'd3)
		else $error("scanner token count out of range");

	a_point_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (head.kind == stl_pkg::KIND_EOF || head.kind == stl_pkg::KIND_ERROR)
			|-> head.start == head.stop)
		else $error("eof or error token with nonzero length");

endmodule

`default_nettype wire
